FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge of clk, held off during reset
`define AAUV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// same, without the reset hold-off
`define AAUV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/aauv_pkg.sv
// constants, types and state encoding for the angle unwrap and velocity block
package aauv_pkg;

  localparam int SENSOR_BITS = 12;
  localparam int RAW_W       = SENSOR_BITS;
  localparam int DELTA_W     = RAW_W + 1;
  localparam int TURN_W      = 32;
  localparam int ANGLE_W     = 32;
  localparam int TIME_W      = 32;
  localparam int VEL_W       = 16;
  localparam int FAULT_W     = 8;

  localparam logic [DELTA_W-1:0]        FULL_D = DELTA_W'(1 << RAW_W);
  localparam logic signed [DELTA_W-1:0] HALF_D = DELTA_W'(1 << (RAW_W - 1));

  // millidegrees per full turn, and the velocity scale folded with the divide by 100
  localparam int ANGLE_SCALE = 360000;
  localparam int VEL_SCALE   = 10000;
  localparam int MUL_B_W     = 19;

  // held angle before the 32-bit wrap, and its difference to the held value
  localparam int MDEG_W = TURN_W + MUL_B_W - SENSOR_BITS + 1;
  localparam int DIFF_W = MDEG_W + 1;
  localparam int P_W    = DIFF_W + MUL_B_W + 1;
  localparam int NUM_W  = DIFF_W + 13;

  localparam int DT_W       = 17;
  localparam int QUO_W      = 15;
  localparam int DT_MIN     = 500;
  localparam int DT_MAX     = 100000;
  localparam int VEL_LIMIT  = 32000;
  localparam int FAULT_LIM  = 10;
  localparam int FAULT_MAX  = 255;

  localparam logic REG_INVERT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_ANGLE,
    ST_SCALE,
    ST_DIFF,
    ST_VMUL,
    ST_DSTART,
    ST_DIV,
    ST_FILTER,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                     en;
    logic signed [DIFF_W-1:0] a;
    logic [MUL_B_W-1:0]       b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DT_W-1:0]  denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VEL_W-1:0] quo;
  } div_stat_t;

endpackage

FILE: rtl/absolute_angle_unwrap_velocity.sv
// top level: multi-turn angle unwrap with filtered velocity, sequencer and register port
// Each transaction is one sensor sample or a set-centre command and gives one result.
// A set-centre command or a failed read goes from the unwrap step straight to the output.
// A good read goes on through the angle scaling and the angle difference, and when its time
// step lets the velocity update, through the 15-step shift-subtract divide of the scaled
// angle step by the time step. The divide is skipped when the quotient is already past the
// clamp. A new result waits in the sequencer while the previous result still
// waits in the output register. The angle and velocity scaling share one multiplier, used
// once for each. in_ready is high only while the sequencer is idle; the result sits in an
// output register, so a new sample can be accepted while the previous result still waits.
// The invert register is at byte address 0 and should only be written while no
// transaction is in flight.
`include "assert_macros.svh"

module absolute_angle_unwrap_velocity import aauv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic [RAW_W-1:0]        raw_angle,
  input  logic                    read_ok,
  input  logic [TIME_W-1:0]       now_us,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANGLE_W-1:0] angle_mdeg,
  output logic signed [VEL_W-1:0]   velocity_ddeg_s,
  output logic                    healthy
);

  state_t state, state_next;

  logic                     invert;
  logic                     func_q;
  logic [RAW_W-1:0]         raw_q;
  logic                     ok_q;
  logic [TIME_W-1:0]        now_q;

  logic [RAW_W-1:0]         previous_raw;
  logic                     previous_valid;
  logic [TURN_W-1:0]        turn_count;
  logic [TURN_W-1:0]        centre_count;
  logic [FAULT_W-1:0]       fault_run;
  logic [TIME_W-1:0]        previous_time;
  logic [ANGLE_W-1:0]       held_angle;
  logic signed [VEL_W-1:0]  filtered_velocity;

  logic                     healthy_q;
  logic signed [MDEG_W-1:0] mdeg_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic                     vel_upd;
  logic [DT_W-1:0]          dt_q;
  logic                     vneg;

  mul_req_t              mul_req;
  logic signed [P_W-1:0] prod;
  div_req_t              div_req;
  div_stat_t             div_stat;

  logic                     apb_write;
  logic signed [DELTA_W-1:0] delta_raw;
  logic signed [DELTA_W-1:0] delta;
  logic [FAULT_W-1:0]       fault_inc;
  logic [TURN_W-1:0]        rel;
  logic signed [P_W-1:0]    prod_adj;
  logic signed [P_W-1:0]    prod_shr;
  logic signed [MDEG_W-1:0] mdeg;
  logic [TIME_W-1:0]        dt;
  logic [P_W-1:0]           prod_mag;
  logic signed [VEL_W:0]    vel_new;
  logic signed [VEL_W+1:0]  err;
  logic signed [VEL_W+1:0]  err_adj;
  logic signed [VEL_W+1:0]  err_step;
  logic                     emit_free;

  aauv_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  aauv_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  // register port
  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_INVERT) ? {31'd0, invert} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert <= 1'b0;
    end else if (apb_write && (paddr[2] == REG_INVERT)) begin
      invert <= pwdata[0];
    end
  end

  // unwrap across the zero seam
  always_comb begin
    delta_raw = $signed({1'b0, raw_q}) - $signed({1'b0, previous_raw});
    if (delta_raw > HALF_D) begin
      delta = delta_raw - $signed(FULL_D);
    end else if (delta_raw < -HALF_D) begin
      delta = delta_raw + $signed(FULL_D);
    end else begin
      delta = delta_raw;
    end
  end

  assign fault_inc = (fault_run == FAULT_W'(FAULT_MAX)) ? fault_run : fault_run + 8'd1;
  assign rel       = turn_count - centre_count;

  // millidegrees, truncated toward zero
  assign prod_adj = prod + ((prod < 0) ? P_W'((1 << SENSOR_BITS) - 1) : P_W'(0));
  assign prod_shr = prod_adj >>> SENSOR_BITS;
  assign mdeg     = invert ? -MDEG_W'(prod_shr) : MDEG_W'(prod_shr);

  assign dt       = now_q - previous_time;
  assign prod_mag = (prod < 0) ? P_W'(-prod) : P_W'(prod);

  // quarter-gain low-pass, step truncated toward zero
  assign vel_new  = vneg ? -$signed({1'b0, div_stat.quo}) : $signed({1'b0, div_stat.quo});
  assign err      = (VEL_W+2)'(vel_new) - (VEL_W+2)'(filtered_velocity);
  assign err_adj  = err + ((err < 0) ? (VEL_W+2)'(3) : (VEL_W+2)'(0));
  assign err_step = err_adj >>> 2;

  assign emit_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_UNWRAP;
        end
      end
      ST_UNWRAP: begin
        if (func_q || !ok_q) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE:  state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DIFF;
      ST_DIFF: begin
        state_next = vel_upd ? ST_VMUL : ST_EMIT;
      end
      ST_VMUL:   state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FILTER;
        end
      end
      ST_FILTER: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mul_req.en    = 1'b0;
    mul_req.a     = DIFF_W'($signed(rel));
    mul_req.b     = MUL_B_W'(ANGLE_SCALE);
    div_req.start = 1'b0;
    div_req.numer = NUM_W'(prod_mag);
    div_req.denom = dt_q;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_ANGLE:  mul_req.en = 1'b1;
      ST_VMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = diff_q;
        mul_req.b  = MUL_B_W'(VEL_SCALE);
      end
      ST_DSTART: div_req.start = 1'b1;
      default: begin
      end
    endcase
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw      <= '0;
      previous_valid    <= 1'b0;
      turn_count        <= '0;
      centre_count      <= '0;
      fault_run         <= '0;
      previous_time     <= '0;
      held_angle        <= '0;
      filtered_velocity <= '0;
    end else begin
      case (state)
        ST_UNWRAP: begin
          if (func_q) begin
            centre_count <= turn_count;
          end else if (!ok_q) begin
            fault_run <= fault_inc;
          end else begin
            fault_run      <= '0;
            previous_raw   <= raw_q;
            previous_valid <= 1'b1;
            if (previous_valid) begin
              turn_count <= turn_count + TURN_W'(delta);
            end
          end
        end
        ST_DIFF: begin
          held_angle    <= mdeg_q[ANGLE_W-1:0];
          previous_time <= now_q;
        end
        ST_FILTER: begin
          filtered_velocity <= filtered_velocity + VEL_W'(err_step);
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q <= func;
      raw_q  <= raw_angle;
      ok_q   <= read_ok;
      now_q  <= now_us;
    end
    case (state)
      ST_UNWRAP: begin
        if (func_q) begin
          healthy_q <= fault_run < FAULT_W'(FAULT_LIM);
        end else if (!ok_q) begin
          healthy_q <= fault_inc < FAULT_W'(FAULT_LIM);
        end else begin
          healthy_q <= 1'b1;
        end
      end
      ST_SCALE: begin
        mdeg_q  <= mdeg;
        vel_upd <= (previous_time != '0) && (dt >= TIME_W'(DT_MIN)) &&
                   (dt < TIME_W'(DT_MAX));
        dt_q    <= dt[DT_W-1:0];
      end
      ST_DIFF: begin
        diff_q <= DIFF_W'(mdeg_q) - DIFF_W'($signed(held_angle));
      end
      ST_DSTART: begin
        vneg <= prod < 0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && emit_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_free) begin
      angle_mdeg      <= $signed(held_angle);
      velocity_ddeg_s <= filtered_velocity;
      healthy         <= healthy_q;
    end
  end

  `AAUV_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
  `AAUV_ASSERT(a_vel_range, out_valid |-> ((velocity_ddeg_s <= 16'sd32000) && (velocity_ddeg_s >= -16'sd32000)), "velocity out of range")
  `AAUV_ASSERT(a_fault_cleared, (state == ST_ANGLE) |-> (fault_run == '0), "fault run not cleared on good read")
  `AAUV_ASSERT(a_div_done_state, div_stat.done |-> (state == ST_DIV), "divider finished outside divide step")

endmodule

FILE: rtl/aauv_mul.sv
// shared signed multiplier with a registered product
module aauv_mul import aauv_pkg::*; (
  input  logic                  clk,
  input  mul_req_t              req,
  output logic signed [P_W-1:0] prod
);

  logic signed [P_W-1:0] op_a;
  logic signed [P_W-1:0] op_b;

  assign op_a = P_W'(req.a);
  assign op_b = P_W'($signed({1'b0, req.b}));

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

FILE: rtl/aauv_div.sv
// shift-subtract divider, one quotient bit per cycle, saturating at the velocity limit
module aauv_div import aauv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic              busy;
  logic              done;
  logic              sat;
  logic [3:0]        cnt;
  logic [DT_W-1:0]   rem;
  logic [DT_W-1:0]   denom;
  logic [QUO_W-1:0]  low;
  logic [QUO_W-1:0]  quo;
  logic              ovf;
  logic [DT_W:0]     rem_sh;
  logic              ge;

  // quotient of 2^15 or more is past the clamp anyway
  assign ovf    = req.numer[NUM_W-1:QUO_W] >= (NUM_W - QUO_W)'(req.denom);
  assign rem_sh = {rem, low[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= !ovf;
        done <= ovf;
      end else if (busy) begin
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sat   <= ovf;
      cnt   <= 4'(QUO_W);
      denom <= req.denom;
      rem   <= req.numer[QUO_W +: DT_W];
      low   <= req.numer[QUO_W-1:0];
      quo   <= '0;
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      rem <= ge ? DT_W'(rem_sh - {1'b0, denom}) : rem_sh[DT_W-1:0];
      low <= {low[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  always_comb begin
    stat.done = done;
    if (sat || (VEL_W'(quo) > VEL_W'(VEL_LIMIT))) begin
      stat.quo = VEL_W'(VEL_LIMIT);
    end else begin
      stat.quo = VEL_W'(quo);
    end
  end

endmodule

FILE: test/absolute_angle_unwrap_velocity_tb.sv
// self-checking testbench for the multi-turn angle unwrap and velocity block
module absolute_angle_unwrap_velocity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aauv_pkg::*;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CENTRE = 1'b1;
  localparam logic [2:0] INVERT_ADDR = {REG_INVERT, 2'b00};

  localparam longint FULL_TURN     = longint'(1) << SENSOR_BITS;
  localparam longint HALF_TURN     = longint'(1) << (SENSOR_BITS - 1);
  localparam longint MDEG_PER_TURN = 360000;
  localparam longint USEC_PER_SEC  = 1000000;
  localparam longint MDEG_PER_DDEG = 100;
  localparam longint VEL_CLAMP     = 32000;
  localparam longint FILTER_DIV    = 4;
  localparam int     DT_LOW        = 500;
  localparam int     DT_HIGH       = 100000;
  localparam int     FAULT_LIMIT   = 10;
  localparam int     FAULT_CEIL    = 255;

  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 35;
  localparam int PRESSURE_PHASE  = 3;
  localparam int HOLD_CYCLES     = 64;
  localparam int FAULT_BURST     = 262;
  // short fast spin, mostly timed, so the velocity clamp is hit hard
  localparam int SPIN_ITEMS      = 50;
  localparam int SPIN_TIMED      = 40;
  localparam int TAIL_CYCLES     = 40;
  // longest quiet stretch is a held output plus one velocity divide and a sender gap
  localparam int STALL_LIMIT     = 2000;

  typedef struct packed {
    logic              func;
    logic [RAW_W-1:0]  raw;
    logic              read_ok;
    logic [TIME_W-1:0] now;
  } sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [VEL_W-1:0]   vel;
    logic                      healthy;
  } unwrap_result_t;

  typedef struct packed {
    logic           typed;
    sample_t        s;
    unwrap_result_t want;
  } directed_row_t;

  localparam unwrap_result_t NO_WANT = '0;
  localparam unwrap_result_t AT_REST = '{32'sd0, 16'sd0, 1'b1};

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [2:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_ready;
  logic                      func;
  logic [RAW_W-1:0]          raw_angle;
  logic                      read_ok;
  logic [TIME_W-1:0]         now_us;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [ANGLE_W-1:0] angle_mdeg;
  logic signed [VEL_W-1:0]   velocity_ddeg_s;
  logic                      healthy;

  absolute_angle_unwrap_velocity dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .raw_angle       (raw_angle),
    .read_ok         (read_ok),
    .now_us          (now_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .angle_mdeg      (angle_mdeg),
    .velocity_ddeg_s (velocity_ddeg_s),
    .healthy         (healthy)
  );

  // tracked copy of the block state
  logic             invert_setting = 1'b0;
  logic [RAW_W-1:0] last_raw       = '0;
  logic             last_raw_seen  = 1'b0;
  logic [31:0]      turns          = '0;
  logic [31:0]      centre_turns   = '0;
  int unsigned      fault_streak   = 0;
  logic [31:0]      last_stamp     = '0;
  int               held_mdeg      = 0;
  int               vel_filt       = 0;

  unwrap_result_t result_queue[$];

  // stimulus state for the simulated sensor
  logic [RAW_W-1:0]  sensor_pos      = '0;
  logic [TIME_W-1:0] sensor_clock    = 32'd1000;
  int                fail_burst_left = 0;

  logic src_idle_on  = 1'b1;
  logic snk_idle_on  = 1'b1;
  logic hold_out_req = 1'b0;

  int mismatches       = 0;
  int results_seen     = 0;
  int good_reads       = 0;
  int failed_reads     = 0;
  int centre_cmds      = 0;
  int velocity_updates = 0;
  int wrapped_angles   = 0;
  int invert_writes    = 0;

  directed_row_t directed_rows [25] = '{
    '{1'b1, '{FUNC_CENTRE, 12'hFFF, 1'b1, 32'hFFFF_FFFF}, AT_REST},
    '{1'b1, '{FUNC_SAMPLE, 12'hFFF, 1'b0, 32'hFFFF_FFFF}, AT_REST},
    '{1'b1, '{FUNC_SAMPLE, 12'd0,    1'b1, 32'd0},        AT_REST},
    '{1'b1, '{FUNC_SAMPLE, 12'd4095, 1'b1, 32'd1000},     '{-32'sd87, 16'sd0, 1'b1}},
    '{1'b0, '{FUNC_SAMPLE, 12'd0,    1'b1, 32'd1500},     NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd2048, 1'b1, 32'd1999},     NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd0,    1'b1, 32'd101998},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd2048, 1'b1, 32'd201998},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4095, 1'b1, 32'd202498},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd2046, 1'b1, 32'd202998},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4093, 1'b1, 32'd203498},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd2044, 1'b1, 32'd203998},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4093, 1'b1, 32'd204498},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd2046, 1'b1, 32'd204998},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4095, 1'b1, 32'd205498},   NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4095, 1'b1, 32'hFFFF_FFFF}, NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4000, 1'b1, 32'h0000_02FF}, NO_WANT},
    '{1'b0, '{FUNC_CENTRE, 12'd0,    1'b0, 32'd0},        NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4000, 1'b1, 32'h0000_06FF}, NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4010, 1'b1, 32'd0},        NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd4020, 1'b1, 32'd600},      NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'hAAA,  1'b0, 32'h5555_5555}, NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'h555,  1'b0, 32'hAAAA_AAAA}, NO_WANT},
    '{1'b0, '{FUNC_CENTRE, 12'h555,  1'b1, 32'h0F0F_0F0F}, NO_WANT},
    '{1'b0, '{FUNC_SAMPLE, 12'd1000, 1'b1, 32'd1200},     NO_WANT}
  };

  function automatic unwrap_result_t predict_sample(input sample_t s);
    unwrap_result_t r;
    longint         delta;
    longint         rel;
    longint         mdeg;
    longint         diff;
    longint         rate;
    longint         dt_us;
    int             rel32;
    logic [31:0]    dt;
    r.angle   = held_mdeg;
    r.vel     = VEL_W'(vel_filt);
    r.healthy = 1'b1;
    if (s.func == FUNC_CENTRE) begin
      centre_turns = turns;
      centre_cmds++;
      r.healthy = fault_streak < FAULT_LIMIT;
      return r;
    end
    if (s.read_ok == 1'b0) begin
      if (fault_streak < FAULT_CEIL) fault_streak++;
      failed_reads++;
      r.healthy = fault_streak < FAULT_LIMIT;
      return r;
    end
    fault_streak = 0;
    good_reads++;
    // shortest way round the zero seam, an exact half turn keeps its direction
    if (last_raw_seen) begin
      delta = longint'(s.raw) - longint'(last_raw);
      if (delta > HALF_TURN) delta -= FULL_TURN;
      else if (delta < -HALF_TURN) delta += FULL_TURN;
      turns = turns + delta[31:0];
    end
    last_raw      = s.raw;
    last_raw_seen = 1'b1;
    rel32 = turns - centre_turns;
    rel   = rel32;
    mdeg  = rel * MDEG_PER_TURN / FULL_TURN;
    if (invert_setting) mdeg = -mdeg;
    if (last_stamp != 0) begin
      dt = s.now - last_stamp;
      if (dt >= DT_LOW && dt < DT_HIGH) begin
        dt_us = dt;
        diff  = mdeg - held_mdeg;
        rate  = (diff * USEC_PER_SEC) / dt_us;
        rate  = rate / MDEG_PER_DDEG;
        if (rate > VEL_CLAMP) rate = VEL_CLAMP;
        if (rate < -VEL_CLAMP) rate = -VEL_CLAMP;
        vel_filt = vel_filt + int'((rate - vel_filt) / FILTER_DIV);
        velocity_updates++;
      end
    end
    last_stamp = s.now;
    if (mdeg != longint'(int'(mdeg))) wrapped_angles++;
    held_mdeg = int'(mdeg);
    r.angle   = held_mdeg;
    r.vel     = VEL_W'(vel_filt);
    return r;
  endfunction

  // a plausible sensor stream with faults, centre commands and some noise mixed in
  function automatic sample_t motion_sample();
    sample_t     s;
    int unsigned pick;
    int          stride;
    int unsigned gap_us;
    s.func    = FUNC_SAMPLE;
    s.read_ok = 1'b1;
    s.raw     = RAW_W'($urandom);
    s.now     = $urandom;
    if (fail_burst_left > 0) begin
      fail_burst_left--;
      s.read_ok = 1'b0;
      return s;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      s.func    = FUNC_CENTRE;
      s.read_ok = 1'($urandom);
      return s;
    end
    if (pick < 9) begin
      s.read_ok = 1'b0;
      return s;
    end
    if (pick < 11) begin
      fail_burst_left = $urandom_range(8, 13);
      s.read_ok = 1'b0;
      return s;
    end
    if (pick < 15) begin
      s.func    = 1'($urandom);
      s.read_ok = 1'($urandom);
      return s;
    end
    case ($urandom_range(0, 9))
      0: stride = int'($urandom_range(0, 4096)) - 2048;
      1: stride = $urandom_range(0, 1) ? 2047 : -2047;
      2: stride = $urandom_range(0, 1) ? 2048 : -2048;
      default: stride = int'($urandom_range(0, 64)) - 32;
    endcase
    case ($urandom_range(0, 11))
      0: gap_us = $urandom_range(0, DT_LOW - 1);
      1: gap_us = $urandom_range(DT_HIGH, 3 * DT_HIGH);
      2: gap_us = $urandom;
      default: gap_us = $urandom_range(DT_LOW, DT_HIGH - 1);
    endcase
    sensor_pos   = sensor_pos + RAW_W'(stride);
    sensor_clock = sensor_clock + gap_us;
    s.raw = sensor_pos;
    s.now = sensor_clock;
    return s;
  endfunction

  task automatic offer_sample(input sample_t s, input logic typed, input unwrap_result_t want);
    int             gap;
    unwrap_result_t predicted;
    gap = src_idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func      <= s.func;
    raw_angle <= s.raw;
    read_ok   <= s.read_ok;
    now_us    <= s.now;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = predict_sample(s);
    result_queue.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_invert(input logic value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= INVERT_ADDR;
    pwdata  <= {31'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    invert_setting = value;
    invert_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : result_sink
    int             gap;
    unwrap_result_t want;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = snk_idle_on ? $urandom_range(0, 11) : 0;
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (result_queue.size() == 0) begin
        $display("%0t: result with no transaction outstanding: angle %0d, velocity %0d, healthy %0b",
                 $time, angle_mdeg, velocity_ddeg_s, healthy);
        mismatches++;
      end else begin
        want = result_queue.pop_front();
        if (angle_mdeg !== want.angle) begin
          $display("%0t: angle_mdeg expected %0d, got %0d", $time, want.angle, angle_mdeg);
          mismatches++;
        end
        if (velocity_ddeg_s !== want.vel) begin
          $display("%0t: velocity_ddeg_s expected %0d, got %0d", $time, want.vel,
                   velocity_ddeg_s);
          mismatches++;
        end
        if (healthy !== want.healthy) begin
          $display("%0t: healthy expected %0b, got %0b", $time, want.healthy, healthy);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1) || psel === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
             STALL_LIMIT, result_queue.size());
    $display("absolute_angle_unwrap_velocity: mismatch");
    $finish;
  end

  initial begin : stimulus
    sample_t     s;
    int          stride;
    logic [RAW_W-1:0] spin_raw;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    func      = 1'b0;
    raw_angle = '0;
    read_ok   = 1'b0;
    now_us    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_invert(1'b0);
    foreach (directed_rows[i])
      offer_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      write_invert((phase % 2) == 0);
      src_idle_on = (phase != 1 && phase != 5);
      snk_idle_on = (phase != 2 && phase != 5);
      // output held back while samples keep coming, so the input stalls
      if (phase == PRESSURE_PHASE) begin
        src_idle_on  = 1'b0;
        hold_out_req = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) offer_sample(motion_sample(), 1'b0, NO_WANT);
    end

    // long run of bus faults, well past the saturation of the fault count
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    for (int k = 0; k < FAULT_BURST; k++) begin
      s = '{FUNC_SAMPLE, RAW_W'($urandom), 1'b0, $urandom};
      offer_sample(s, 1'b0, NO_WANT);
    end
    offer_sample(motion_sample(), 1'b0, NO_WANT);

    // fast spin from a fresh centre, near half-turn steps at short time steps
    drain_results();
    write_invert(1'($urandom));
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    offer_sample('{FUNC_CENTRE, RAW_W'($urandom), 1'b1, $urandom}, 1'b0, NO_WANT);
    stride   = $urandom_range(0, 1) ? 2047 : -2047;
    spin_raw = RAW_W'($urandom);
    for (int k = 0; k < SPIN_ITEMS; k++) begin
      spin_raw = spin_raw + RAW_W'(stride);
      s.func    = FUNC_SAMPLE;
      s.read_ok = 1'b1;
      s.raw     = spin_raw;
      if (k < SPIN_ITEMS - SPIN_TIMED) begin
        s.now = '0;
      end else begin
        sensor_clock = sensor_clock + $urandom_range(DT_LOW, 3000);
        s.now = sensor_clock;
      end
      offer_sample(s, 1'b0, NO_WANT);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d good reads (%0d velocity updates), %0d failed reads, %0d centre commands",
             good_reads, velocity_updates, failed_reads, centre_cmds);
    $display("invert written %0d times, %0d angles wrapped past 32 bits, %0d results compared",
             invert_writes, wrapped_angles, results_seen);
    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("absolute_angle_unwrap_velocity: match");
    end else begin
      $display("absolute_angle_unwrap_velocity: mismatch");
    end
    $finish;
  end

endmodule
